// ----- rtl/trgg_pkg.sv -----
// Shared types and constants of the triggered ramp and gate generator.
// No dependencies; the front, back and top-level files use it by scoped names.
`default_nettype none
package trgg_pkg;

  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 32;
  localparam int unsigned LevelBits = 16;

  // Schmitt thresholds: 0.1 V and 2 V at 3276.8 LSB per volt.
  localparam logic signed [15:0] TrigLow = 16'sd327;
  localparam logic signed [15:0] TrigHigh = 16'sd6554;

  localparam logic [LevelBits-1:0] LevelFull = '1;
  localparam logic [15:0] EocTimeMax = '1;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_BASE_DURATION = 3'd0,
    REG_CV_SCALE      = 3'd1,
    REG_MAX_DURATION  = 3'd2,
    REG_EOC_LENGTH    = 3'd3,
    REG_FINISH_HIGH   = 3'd4,
    REG_EOC_ON_STOP   = 3'd5,
    REG_HOLD_DURATION = 3'd6
  } trgg_reg_e;

  typedef struct packed {
    logic [21:0]        base_duration;
    logic signed [31:0] cv_gain;
    logic [21:0]        max_duration;
    logic [15:0]        eoc_length;
    logic               finish_level_high;
    logic               eoc_on_stop;
    logic               hold_duration;
  } trgg_cfg_t;

  // What the front part found out about one tick.
  typedef struct packed {
    logic [3:0] channel;
    logic       in_range;
    logic       trig_edge;
    logic       stop_edge;
  } trgg_cls_t;

endpackage
`default_nettype wire

// ----- rtl/trgg_if.sv -----
// Valid/ready channel interfaces for the tick input and the result output.
// No dependencies.
`default_nettype none
interface trgg_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         channel;
  logic signed [15:0] trig_sample;
  logic signed [15:0] stop_sample;
  logic signed [15:0] cv_sample;
  modport source (output valid, channel, trig_sample, stop_sample, cv_sample, input ready);
  modport sink (input valid, channel, trig_sample, stop_sample, cv_sample, output ready);
endinterface

interface trgg_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_channel;
  logic [15:0] ramp_level;
  logic        gate;
  logic        eoc_active;
  logic        finished;
  modport source (output valid, out_channel, ramp_level, gate, eoc_active, finished,
                  input ready);
  modport sink (input valid, out_channel, ramp_level, gate, eoc_active, finished,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/trgg_front.sv -----
// Front part: accepts ticks, runs the per-channel Schmitt triggers and works out
// the modulated duration. Depends on trgg_pkg and trgg_if.
`default_nettype none
module trgg_front #(
  parameter int unsigned CHANNELS  = 16,
  parameter int unsigned TIME_BITS = 22
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire trgg_pkg::trgg_cfg_t  cfg_i,
  trgg_in_if.sink                   in_i,
  output logic                      push_o,
  output trgg_pkg::trgg_cls_t       push_cls_o,
  output logic [TIME_BITS-1:0]      push_dur_o,
  input  wire logic                 full_i
);

  localparam int unsigned IdxBits = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [32:0] TimeMax = (33'd1 << TIME_BITS) - 33'd1;

  logic                busy_q;
  logic signed [47:0]  product_q;
  trgg_pkg::trgg_cls_t cls_q;
  logic [CHANNELS-1:0] trig_latch_q;
  logic [CHANNELS-1:0] stop_latch_q;

  logic               accept;
  logic               in_range;
  logic [IdxBits-1:0] idx;
  logic               trig_edge, stop_edge, trig_new, stop_new;
  logic signed [48:0] sum;
  logic [32:0]        quot, lim;

  assign in_i.ready = !busy_q;
  assign accept = in_i.valid && !busy_q;
  assign in_range = 32'(in_i.channel) < CHANNELS;
  assign idx = IdxBits'(in_i.channel);

  always_comb begin
    if (trig_latch_q[idx]) begin
      trig_edge = 1'b0;
      trig_new = !(in_i.trig_sample <= trgg_pkg::TrigLow);
    end else begin
      trig_edge = in_i.trig_sample >= trgg_pkg::TrigHigh;
      trig_new = trig_edge;
    end
    if (stop_latch_q[idx]) begin
      stop_edge = 1'b0;
      stop_new = !(in_i.stop_sample <= trgg_pkg::TrigLow);
    end else begin
      stop_edge = in_i.stop_sample >= trgg_pkg::TrigHigh;
      stop_new = stop_edge;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      trig_latch_q <= '1;
      stop_latch_q <= '1;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        if (in_range) begin
          trig_latch_q[idx] <= trig_new;
          stop_latch_q[idx] <= stop_new;
        end
      end else if (busy_q && !full_i) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      product_q <= 48'(in_i.cv_sample) * 48'(cfg_i.cv_gain);
      cls_q.channel <= in_i.channel;
      cls_q.in_range <= in_range;
      cls_q.trig_edge <= trig_edge && in_range;
      cls_q.stop_edge <= stop_edge && in_range;
    end
  end

  // Duration: (base * 65536 + cv * scale) / 65536, clamped to zero and to the limit.
  always_comb begin
    sum = 49'({1'b0, cfg_i.base_duration, 16'h0000}) + 49'(product_q);
    quot = 33'(sum[47:16]);
    lim = (33'(cfg_i.max_duration) > TimeMax) ? TimeMax : 33'(cfg_i.max_duration);
    if (sum[48]) begin
      push_dur_o = '0;
    end else if (quot > lim) begin
      push_dur_o = TIME_BITS'(lim);
    end else begin
      push_dur_o = TIME_BITS'(quot);
    end
  end

  assign push_o = busy_q && !full_i;
  assign push_cls_o = cls_q;

endmodule
`default_nettype wire

// ----- rtl/trgg_fifo.sv -----
// Short queue between the front and back parts.
// No dependencies.
`default_nettype none
module trgg_fifo #(
  parameter int unsigned WIDTH = 29,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PtrBits:0] Depth = (PtrBits + 1)'(DEPTH);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);

  logic [WIDTH-1:0]   mem_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrBits:0]   count_q;

  assign full_o = count_q == Depth;
  assign empty_o = count_q == '0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/trgg_back.sv -----
// Back part: per-channel ramp and EOC state, serial level divider, output register.
// Depends on trgg_pkg and trgg_if.
`default_nettype none
module trgg_back #(
  parameter int unsigned CHANNELS  = 16,
  parameter int unsigned TIME_BITS = 22
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire trgg_pkg::trgg_cfg_t        cfg_i,
  input  wire logic                       empty_i,
  input  wire trgg_pkg::trgg_cls_t        cls_i,
  input  wire logic [TIME_BITS-1:0]       dur_i,
  output logic                            pop_o,
  trgg_out_if.source                      out_o
);

  localparam int unsigned IdxBits = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned LB = trgg_pkg::LevelBits;
  localparam logic [TIME_BITS-1:0] TimeMax = '1;
  localparam logic [3:0] LastStep = 4'(LB - 1);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_RES} state_e;

  state_e state_q;
  logic [TIME_BITS-1:0] time_q [CHANNELS];
  logic [TIME_BITS-1:0] dur_q [CHANNELS];
  logic [15:0]          etime_q [CHANNELS];
  logic [CHANNELS-1:0]  rdone_q, edone_q;

  logic [TIME_BITS:0]   rem_q;
  logic [TIME_BITS-1:0] div_q;
  logic [LB-1:0]        quo_q;
  logic [3:0]           step_q;
  logic [3:0]           res_ch_q;
  logic                 res_gate_q, res_eoc_q;

  logic                 out_valid_q;
  logic [3:0]           out_ch_q;
  logic [LB-1:0]        out_level_q;
  logic                 out_gate_q, out_eoc_q;

  logic [IdxBits-1:0]   idx;
  logic [TIME_BITS-1:0] t_n, d_n;
  logic [15:0]          e_n;
  logic                 rd_n, ed_n, eoc_req, was_running;
  logic [TIME_BITS:0]   rem2;
  logic [LB-1:0]        idle_level;
  logic                 load_out;

  assign idx = IdxBits'(cls_i.channel);
  assign idle_level = cfg_i.finish_level_high ? trgg_pkg::LevelFull : '0;
  assign pop_o = (state_q == S_IDLE) && !empty_i;
  assign load_out = (state_q == S_RES) && (!out_valid_q || out_o.ready);

  // Next state of the channel named by the queue head.
  always_comb begin
    t_n = time_q[idx];
    d_n = dur_q[idx];
    e_n = etime_q[idx];
    rd_n = rdone_q[idx];
    ed_n = edone_q[idx];
    eoc_req = 1'b0;
    if (cls_i.stop_edge) begin
      t_n = '0;
      d_n = '0;
      rd_n = 1'b1;
      e_n = '0;
      ed_n = 1'b1;
      eoc_req = cfg_i.eoc_on_stop;
    end else if (cls_i.trig_edge) begin
      t_n = '0;
      rd_n = 1'b0;
      d_n = dur_i;
    end
    if (!cfg_i.hold_duration) begin
      d_n = dur_i;
    end
    was_running = !rd_n;
    if (t_n != TimeMax) begin
      t_n = t_n + 1'b1;
    end
    if (!rd_n) begin
      rd_n = t_n >= d_n;
    end
    if (was_running && rd_n) begin
      eoc_req = 1'b1;
    end
    if (eoc_req) begin
      e_n = '0;
      ed_n = 1'b0;
    end
    if (e_n != trgg_pkg::EocTimeMax) begin
      e_n = e_n + 1'b1;
    end
    if (!ed_n) begin
      ed_n = e_n >= cfg_i.eoc_length;
    end
  end

  // Restoring division step; the remainder stays below the divisor.
  assign rem2 = {rem_q[TIME_BITS-1:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdone_q <= '1;
      edone_q <= '1;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        time_q[i] <= '0;
        dur_q[i] <= '0;
        etime_q[i] <= '0;
      end
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            res_ch_q <= cls_i.channel;
            step_q <= '0;
            quo_q <= '0;
            rem_q <= {1'b0, t_n};
            div_q <= d_n;
            if (cls_i.in_range) begin
              time_q[idx] <= t_n;
              dur_q[idx] <= d_n;
              etime_q[idx] <= e_n;
              rdone_q[idx] <= rd_n;
              edone_q[idx] <= ed_n;
              res_gate_q <= !rd_n;
              res_eoc_q <= !ed_n;
              state_q <= (!rd_n && d_n != '0) ? S_DIV : S_RES;
            end else begin
              res_gate_q <= 1'b0;
              res_eoc_q <= 1'b0;
              state_q <= S_RES;
            end
          end
        end
        S_DIV: begin
          if (rem2 >= {1'b0, div_q}) begin
            rem_q <= rem2 - {1'b0, div_q};
            quo_q <= {quo_q[LB-2:0], 1'b1};
          end else begin
            rem_q <= rem2;
            quo_q <= {quo_q[LB-2:0], 1'b0};
          end
          step_q <= step_q + 1'b1;
          if (step_q == LastStep) begin
            state_q <= S_RES;
          end
        end
        S_RES: begin
          if (load_out) begin
            out_ch_q <= res_ch_q;
            out_level_q <= res_gate_q ? quo_q : idle_level;
            out_gate_q <= res_gate_q;
            out_eoc_q <= res_eoc_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.out_channel = out_ch_q;
  assign out_o.ramp_level = out_level_q;
  assign out_o.gate = out_gate_q;
  assign out_o.eoc_active = out_eoc_q;
  assign out_o.finished = !out_gate_q;

endmodule
`default_nettype wire

// ----- rtl/triggered_ramp_gate_generator.sv -----
// Top level of the triggered ramp and gate generator: configuration registers,
// front part, queue and back part. Depends on trgg_pkg, trgg_if and the trgg_* modules.
//
// Each input beat is one sample tick of one channel and yields one output beat.
// The front part works on one beat at a time (Schmitt triggers and a 16x32
// multiply, then the clamped duration) and hands it to a two-entry queue before
// it takes the next. The back part updates the channel state, runs the bit-serial
// level divider while the gate is high, and loads the output register once the
// output is free, before it pops the next tick. Configuration writes take effect
// at once and belong in idle periods.
`default_nettype none
module triggered_ramp_gate_generator #(
  parameter int unsigned CHANNELS  = 16,
  parameter int unsigned TIME_BITS = 22
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [trgg_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  wire logic [trgg_pkg::CfgDataBits-1:0]    cfg_wdata_i,
  trgg_in_if.sink                                  in_i,
  trgg_out_if.source                               out_o
);

  localparam int unsigned QWidth = $bits(trgg_pkg::trgg_cls_t) + TIME_BITS;

  trgg_pkg::trgg_cfg_t cfg_q;
  logic                push, full, pop, empty;
  trgg_pkg::trgg_cls_t push_cls, pop_cls;
  logic [TIME_BITS-1:0] push_dur, pop_dur;
  logic [QWidth-1:0]   qdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_duration <= 22'd240000;
      cfg_q.cv_gain <= '0;
      cfg_q.max_duration <= 22'd480000;
      cfg_q.eoc_length <= 16'd48;
      cfg_q.finish_level_high <= 1'b0;
      cfg_q.eoc_on_stop <= 1'b0;
      cfg_q.hold_duration <= 1'b0;
    end else if (cfg_we_i) begin
      case (trgg_pkg::trgg_reg_e'(cfg_index_i))
        trgg_pkg::REG_BASE_DURATION: cfg_q.base_duration <= cfg_wdata_i[21:0];
        trgg_pkg::REG_CV_SCALE:      cfg_q.cv_gain <= cfg_wdata_i;
        trgg_pkg::REG_MAX_DURATION:  cfg_q.max_duration <= cfg_wdata_i[21:0];
        trgg_pkg::REG_EOC_LENGTH:    cfg_q.eoc_length <= cfg_wdata_i[15:0];
        trgg_pkg::REG_FINISH_HIGH:   cfg_q.finish_level_high <= cfg_wdata_i[0];
        trgg_pkg::REG_EOC_ON_STOP:   cfg_q.eoc_on_stop <= cfg_wdata_i[0];
        trgg_pkg::REG_HOLD_DURATION: cfg_q.hold_duration <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  trgg_front #(.CHANNELS(CHANNELS), .TIME_BITS(TIME_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_i       (in_i),
    .push_o     (push),
    .push_cls_o (push_cls),
    .push_dur_o (push_dur),
    .full_i     (full)
  );

  trgg_fifo #(.WIDTH(QWidth), .DEPTH(2)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({push_cls, push_dur}),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (qdata),
    .empty_o (empty)
  );

  assign pop_cls = trgg_pkg::trgg_cls_t'(qdata[QWidth-1:TIME_BITS]);
  assign pop_dur = qdata[TIME_BITS-1:0];

  trgg_back #(.CHANNELS(CHANNELS), .TIME_BITS(TIME_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .cls_i   (pop_cls),
    .dur_i   (pop_dur),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire

// ----- rtl/trgg_checker.sv -----
// Port-level checks of the triggered ramp and gate generator, bound to its top level.
// Depends on the top level's ports only.
`default_nettype none
module trgg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [3:0]  out_channel_i,
  input wire logic [15:0] ramp_level_i,
  input wire logic        gate_i,
  input wire logic        eoc_active_i,
  input wire logic        finished_i
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_channel_i) && $stable(ramp_level_i)
      && $stable(gate_i) && $stable(eoc_active_i))
    else $error("output payload changed while stalled");

  a_finished_inverse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> finished_i != gate_i)
    else $error("finished is not the inverse of gate");

  a_idle_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !gate_i |-> ramp_level_i == 16'h0000 || ramp_level_i == 16'hFFFF)
    else $error("idle ramp level is neither zero nor full scale");

endmodule

bind triggered_ramp_gate_generator trgg_checker u_trgg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_channel_i (out_o.out_channel),
  .ramp_level_i  (out_o.ramp_level),
  .gate_i        (out_o.gate),
  .eoc_active_i  (out_o.eoc_active),
  .finished_i    (out_o.finished)
);
`default_nettype wire
